### rtl/core/lld_pkg.sv
// Shared types and codes for the sorted linked list deque core.
package lld_pkg;

  localparam int unsigned NODES_DEF    = 256;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned NODE_W       = 8;
  localparam int unsigned IN_KEY_W     = 32;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_UNSHIFT = 3'd1,
    CMD_POP     = 3'd2,
    CMD_SHIFT   = 3'd3,
    CMD_INSERT  = 3'd4,
    CMD_DELETE  = 3'd5,
    CMD_SEARCH  = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    HIT_NONE,
    HIT_TAIL,
    HIT_ANY,
    HIT_NODE,
    HIT_GE,
    HIT_EQ
  } hit_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_REMOVE
  } act_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  // Control broadcast to every cell.
  typedef struct packed {
    hit_e              mode;
    act_e              act;
    logic              clear;
    logic              any;
    logic [NODE_W-1:0] node;
  } ctl_t;

  // First-hit token rippled along the chain.
  typedef struct packed {
    logic              found;
    logic              eq;
    logic [NODE_W-1:0] node;
  } fw_t;

endpackage

### rtl/core/linked_list_deque_sorted_core.sv
// Top level of the sorted linked list deque: command decode and the cell chain.
//
//  channel  | direction | handshake        | beat fields
//  command  | in        | start_i, busy_o  | command_i, node_i, key_i
//  result   | out       | done_o (strobe)  | status_o, node_out_o, node_valid_o
//
// The list is kept in list order in a chain of NODES cells, head in cell 0.
// A rejected or unknown command answers in the cycle after its beat is taken.
// Every other command is latched, then the first-hit token ripples through
// the chain one cell a cycle during the scan, then the apply state answers.
// Reset clears all cells, the membership bits and the control at once.
// The receiver cannot stall: the result beat shows for exactly one cycle.
module linked_list_deque_sorted_core #(
  parameter int unsigned NODES    = lld_pkg::NODES_DEF,
  parameter int unsigned KEY_BITS = lld_pkg::KEY_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [lld_pkg::CMD_W-1:0]          command_i,
  input  logic [lld_pkg::NODE_W-1:0]         node_i,
  input  logic signed [lld_pkg::IN_KEY_W-1:0] key_i,
  output logic                               done_o,
  output logic [lld_pkg::STATUS_W-1:0]       status_o,
  output logic [lld_pkg::NODE_W-1:0]         node_out_o,
  output logic                               node_valid_o
);

  localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CNT_W = (NODES > 1) ? $clog2(NODES) : 1;

  lld_pkg::state_e                   state_q, state_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [lld_pkg::CMD_W-1:0]         cmd_q;
  logic [lld_pkg::NODE_W-1:0]        node_q;
  logic signed [KEY_BITS-1:0]        key_q;
  logic [NODES-1:0]                  member_q;
  logic [lld_pkg::STATUS_W-1:0]      status_q, status_d;
  logic [lld_pkg::NODE_W-1:0]        nout_q, nout_d;
  logic                              nvalid_q, nvalid_d;
  logic                              done_q, done_d;

  logic                              accept;
  logic                              slot_ok;
  logic                              listed;
  logic                              reject_now;
  logic                              set_member;
  logic                              clr_member;
  lld_pkg::hit_e                     mode_sel;
  lld_pkg::act_e                     act_sel;
  lld_pkg::ctl_t                     ctl;
  lld_pkg::fw_t                      fw_end;

  logic [NODES-1:0]                  cell_valid;
  logic [lld_pkg::NODE_W-1:0]        cell_node [NODES];
  logic signed [KEY_BITS-1:0]        cell_key  [NODES];
  lld_pkg::fw_t                      cell_fw   [NODES];

  assign busy_o = (state_q != lld_pkg::S_IDLE);
  assign accept = start_i & ~busy_o;

  // Check the slot against the pool and the membership bits.
  assign slot_ok = (int'(node_i) < NODES);
  assign listed  = slot_ok & member_q[IDX_W'(node_i)];

  always_comb begin
    case (command_i)
      lld_pkg::CMD_PUSH, lld_pkg::CMD_UNSHIFT, lld_pkg::CMD_INSERT:
        reject_now = ~slot_ok | listed;
      lld_pkg::CMD_DELETE:
        reject_now = ~slot_ok | ~listed;
      lld_pkg::CMD_POP, lld_pkg::CMD_SHIFT, lld_pkg::CMD_SEARCH:
        reject_now = 1'b0;
      default:
        reject_now = 1'b1;
    endcase
  end

  // Map the latched command onto a hit rule and a chain action.
  always_comb begin
    case (cmd_q)
      lld_pkg::CMD_PUSH:    begin mode_sel = lld_pkg::HIT_NONE; act_sel = lld_pkg::ACT_INSERT; end
      lld_pkg::CMD_UNSHIFT: begin mode_sel = lld_pkg::HIT_ANY;  act_sel = lld_pkg::ACT_INSERT; end
      lld_pkg::CMD_POP:     begin mode_sel = lld_pkg::HIT_TAIL; act_sel = lld_pkg::ACT_REMOVE; end
      lld_pkg::CMD_SHIFT:   begin mode_sel = lld_pkg::HIT_ANY;  act_sel = lld_pkg::ACT_REMOVE; end
      lld_pkg::CMD_INSERT:  begin mode_sel = lld_pkg::HIT_GE;   act_sel = lld_pkg::ACT_INSERT; end
      lld_pkg::CMD_DELETE:  begin mode_sel = lld_pkg::HIT_NODE; act_sel = lld_pkg::ACT_REMOVE; end
      default:              begin mode_sel = lld_pkg::HIT_EQ;   act_sel = lld_pkg::ACT_NONE;   end
    endcase
  end

  assign fw_end = cell_fw[NODES-1];

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      lld_pkg::S_IDLE: begin
        if (accept && !reject_now) begin
          state_d = lld_pkg::S_SCAN;
          cnt_d   = '0;
        end
      end
      lld_pkg::S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NODES - 1)) begin
          state_d = lld_pkg::S_APPLY;
        end
      end
      lld_pkg::S_APPLY: begin
        state_d = lld_pkg::S_IDLE;
      end
      default: begin
        state_d = lld_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: chain control, result beat, membership updates.
  always_comb begin
    ctl.mode   = mode_sel;
    ctl.act    = lld_pkg::ACT_NONE;
    ctl.clear  = accept;
    ctl.any    = fw_end.found;
    ctl.node   = node_q;
    status_d   = status_q;
    nout_d     = nout_q;
    nvalid_d   = nvalid_q;
    done_d     = 1'b0;
    set_member = 1'b0;
    clr_member = 1'b0;
    case (state_q)
      lld_pkg::S_IDLE: begin
        if (accept && reject_now) begin
          done_d   = 1'b1;
          status_d = lld_pkg::ST_REJECT;
          // Hand the slot back on slot commands; drop it on an unknown code.
          nvalid_d = (command_i inside {lld_pkg::CMD_PUSH, lld_pkg::CMD_UNSHIFT,
                                        lld_pkg::CMD_INSERT, lld_pkg::CMD_DELETE});
          nout_d   = nvalid_d ? node_i : '0;
        end
      end
      lld_pkg::S_APPLY: begin
        done_d = 1'b1;
        case (act_sel)
          lld_pkg::ACT_INSERT: begin
            if ((cmd_q == lld_pkg::CMD_INSERT) && fw_end.found && fw_end.eq) begin
              status_d = lld_pkg::ST_REJECT;
              nout_d   = node_q;
              nvalid_d = 1'b1;
            end else begin
              ctl.act    = lld_pkg::ACT_INSERT;
              set_member = 1'b1;
              status_d   = lld_pkg::ST_DONE;
              nout_d     = '0;
              nvalid_d   = 1'b0;
            end
          end
          lld_pkg::ACT_REMOVE: begin
            if (fw_end.found) begin
              ctl.act    = lld_pkg::ACT_REMOVE;
              clr_member = 1'b1;
              status_d   = lld_pkg::ST_DONE;
              nout_d     = fw_end.node;
              nvalid_d   = 1'b1;
            end else begin
              status_d = lld_pkg::ST_EMPTY;
              nout_d   = '0;
              nvalid_d = 1'b0;
            end
          end
          default: begin
            status_d = fw_end.found ? lld_pkg::ST_DONE : lld_pkg::ST_EMPTY;
            nout_d   = fw_end.found ? fw_end.node : '0;
            nvalid_d = fw_end.found;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lld_pkg::S_IDLE;
      cnt_q    <= '0;
      member_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (set_member) begin
        member_q[IDX_W'(node_q)] <= 1'b1;
      end
      if (clr_member) begin
        member_q[IDX_W'(fw_end.node)] <= 1'b0;
      end
    end
  end

  // Latch the command beat and hold the result beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      node_q <= node_i;
      key_q  <= KEY_BITS'(key_i);
    end
    status_q <= status_d;
    nout_q   <= nout_d;
    nvalid_q <= nvalid_d;
  end

  genvar gi;
  generate
    for (gi = 0; gi < NODES; gi++) begin : g_cell
      logic                       lv;
      logic [lld_pkg::NODE_W-1:0] ln;
      logic signed [KEY_BITS-1:0] lk;
      logic                       rv;
      logic [lld_pkg::NODE_W-1:0] rn;
      logic signed [KEY_BITS-1:0] rk;
      lld_pkg::fw_t               fi;

      if (gi == 0) begin : g_head
        assign lv = 1'b1;
        assign ln = '0;
        assign lk = '0;
        assign fi = '0;
      end else begin : g_mid
        assign lv = cell_valid[gi-1];
        assign ln = cell_node[gi-1];
        assign lk = cell_key[gi-1];
        assign fi = cell_fw[gi-1];
      end

      if (gi == NODES - 1) begin : g_tail
        assign rv = 1'b0;
        assign rn = '0;
        assign rk = '0;
      end else begin : g_inner
        assign rv = cell_valid[gi+1];
        assign rn = cell_node[gi+1];
        assign rk = cell_key[gi+1];
      end

      lld_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctl_i         (ctl),
        .key_i         (key_q),
        .left_valid_i  (lv),
        .left_node_i   (ln),
        .left_key_i    (lk),
        .right_valid_i (rv),
        .right_node_i  (rn),
        .right_key_i   (rk),
        .fw_i          (fi),
        .fw_o          (cell_fw[gi]),
        .valid_o       (cell_valid[gi]),
        .node_o        (cell_node[gi]),
        .key_o         (cell_key[gi])
      );
    end
  endgenerate

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign node_out_o   = nout_q;
  assign node_valid_o = nvalid_q;

`ifndef NO_ASSERTIONS
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lld_pkg::S_SCAN && cnt_q == CNT_W'(NODES - 1)) |=>
      state_q == lld_pkg::S_APPLY)
    else $error("scan did not end in apply");

  a_apply_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lld_pkg::S_APPLY) |=> done_o)
    else $error("apply gave no result beat");

  a_accept_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o))
    else $error("accepted beat neither busy nor answered");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == lld_pkg::ST_DONE || status_o == lld_pkg::ST_REJECT ||
                status_o == lld_pkg::ST_EMPTY))
    else $error("bad status code");

  a_no_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lld_pkg::S_SCAN) |-> !done_o || $past(state_q) == lld_pkg::S_IDLE)
    else $error("result beat in the middle of a scan");
`endif

endmodule

### rtl/core/lld_cell.sv
// One list position: holds a slot and its key, shifts with its neighbors.
module lld_cell #(
  parameter int unsigned KEY_BITS = lld_pkg::KEY_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lld_pkg::ctl_t                     ctl_i,
  input  logic signed [KEY_BITS-1:0]        key_i,
  input  logic                              left_valid_i,
  input  logic [lld_pkg::NODE_W-1:0]        left_node_i,
  input  logic signed [KEY_BITS-1:0]        left_key_i,
  input  logic                              right_valid_i,
  input  logic [lld_pkg::NODE_W-1:0]        right_node_i,
  input  logic signed [KEY_BITS-1:0]        right_key_i,
  input  lld_pkg::fw_t                      fw_i,
  output lld_pkg::fw_t                      fw_o,
  output logic                              valid_o,
  output logic [lld_pkg::NODE_W-1:0]        node_o,
  output logic signed [KEY_BITS-1:0]        key_o
);

  logic                           valid_q, valid_d;
  logic [lld_pkg::NODE_W-1:0]     node_q, node_d;
  logic signed [KEY_BITS-1:0]     key_q, key_d;
  lld_pkg::fw_t                   fw_q, fw_d;
  logic                           hit;
  logic                           first;
  logic                           after;

  always_comb begin
    case (ctl_i.mode)
      lld_pkg::HIT_NONE: hit = 1'b0;
      lld_pkg::HIT_TAIL: hit = valid_q & ~right_valid_i;
      lld_pkg::HIT_ANY:  hit = valid_q;
      lld_pkg::HIT_NODE: hit = valid_q & (node_q == ctl_i.node);
      lld_pkg::HIT_GE:   hit = valid_q & (key_q >= key_i);
      lld_pkg::HIT_EQ:   hit = valid_q & (key_q == key_i);
      default:           hit = 1'b0;
    endcase
  end

  assign first = hit & ~fw_i.found;
  assign after = fw_i.found;

  // Clear on a new command, else pass the first hit on, or announce this one.
  always_comb begin
    if (ctl_i.clear) begin
      fw_d = '0;
    end else if (fw_i.found) begin
      fw_d = fw_i;
    end else begin
      fw_d.found = hit;
      fw_d.eq    = hit & (key_q == key_i);
      fw_d.node  = node_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    node_d  = node_q;
    key_d   = key_q;
    case (ctl_i.act)
      lld_pkg::ACT_INSERT: begin
        if (first || (!ctl_i.any && !valid_q && left_valid_i)) begin
          valid_d = 1'b1;
          node_d  = ctl_i.node;
          key_d   = key_i;
        end else if (after) begin
          valid_d = left_valid_i;
          node_d  = left_node_i;
          key_d   = left_key_i;
        end
      end
      lld_pkg::ACT_REMOVE: begin
        if (first || after) begin
          valid_d = right_valid_i;
          node_d  = right_node_i;
          key_d   = right_key_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fw_q    <= '0;
    end else begin
      valid_q <= valid_d;
      fw_q    <= fw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    key_q  <= key_d;
  end

  assign fw_o    = fw_q;
  assign valid_o = valid_q;
  assign node_o  = node_q;
  assign key_o   = key_q;

endmodule

### bench/tb_top.sv
// Self-checking testbench for the sorted linked list deque core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lld_pkg::*;

  localparam int unsigned NODES     = NODES_DEF;
  localparam int          NIL       = NODES;
  localparam int          LATENCY   = NODES + 2;
  localparam int          WDOG_MAX  = 4 * LATENCY + 200;
  localparam int          N_RANDOM  = 1330;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] KEY_MIN = 32'sh80000000;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [NODE_W-1:0]   node;
    logic signed [31:0]  key;
    bit                  typed;   // expectation written in the table
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node_out;
    logic                node_valid;
  } stim_row_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node_out;
    logic                node_valid;
  } answer_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [CMD_W-1:0]           command_i;
  logic [NODE_W-1:0]          node_i;
  logic signed [IN_KEY_W-1:0] key_i;
  logic                       done_o;
  logic [STATUS_W-1:0]        status_o;
  logic [NODE_W-1:0]          node_out_o;
  logic                       node_valid_o;

  linked_list_deque_sorted_core dut (.*);

  // Shadow copy of the list held by the core.
  int                 list_head;
  int                 list_tail;
  int                 link_next [NODES];
  int                 link_prev [NODES];
  logic signed [31:0] slot_key  [NODES];
  bit                 in_list   [NODES];
  int                 list_len;

  answer_t   pending_answers[$];
  stim_row_t directed[$];
  int        mismatches = 0;
  int        idle_cycles;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic detach_slot(input int n);
    int p;
    int q;
    p = link_prev[n];
    q = link_next[n];
    if (p != NIL) link_next[p] = q; else list_head = q;
    if (q != NIL) link_prev[q] = p; else list_tail = p;
    link_prev[n] = NIL;
    link_next[n] = NIL;
    in_list[n]   = 0;
    list_len--;
  endtask

  // Link n in front of slot x; x at NIL means append at the tail.
  task automatic attach_before(input int n, input int x);
    int p;
    p = (x != NIL) ? link_prev[x] : list_tail;
    link_prev[n] = p;
    link_next[n] = x;
    if (p != NIL) link_next[p] = n; else list_head = n;
    if (x != NIL) link_prev[x] = n; else list_tail = n;
    in_list[n] = 1;
    list_len++;
  endtask

  // Apply one command to the shadow list and return the answer it gives.
  task automatic apply_list_cmd(input logic [CMD_W-1:0] c, input logic [NODE_W-1:0] nd,
                                input logic signed [31:0] k, output answer_t a);
    int n;
    int x;
    n = nd;
    a = '{ST_DONE, '0, 1'b0};
    case (c)
      CMD_PUSH, CMD_UNSHIFT: begin
        if (in_list[n]) begin
          a = '{ST_REJECT, nd, 1'b1};
        end else begin
          slot_key[n] = k;
          attach_before(n, (c == CMD_PUSH) ? NIL : list_head);
        end
      end
      CMD_POP, CMD_SHIFT: begin
        x = (c == CMD_POP) ? list_tail : list_head;
        if (x == NIL) begin
          a = '{ST_EMPTY, '0, 1'b0};
        end else begin
          detach_slot(x);
          a = '{ST_DONE, x[NODE_W-1:0], 1'b1};
        end
      end
      CMD_INSERT: begin
        if (in_list[n]) begin
          a = '{ST_REJECT, nd, 1'b1};
        end else begin
          x = list_head;
          while (x != NIL && slot_key[x] < k) x = link_next[x];
          if (x != NIL && slot_key[x] == k) begin
            a = '{ST_REJECT, nd, 1'b1};
          end else begin
            slot_key[n] = k;
            attach_before(n, x);
          end
        end
      end
      CMD_DELETE: begin
        if (!in_list[n]) begin
          a = '{ST_REJECT, nd, 1'b1};
        end else begin
          detach_slot(n);
          a = '{ST_DONE, nd, 1'b1};
        end
      end
      CMD_SEARCH: begin
        x = list_head;
        while (x != NIL && slot_key[x] != k) x = link_next[x];
        if (x == NIL) a = '{ST_EMPTY, '0, 1'b0};
        else          a = '{ST_DONE, x[NODE_W-1:0], 1'b1};
      end
      default: a = '{ST_REJECT, '0, 1'b0};
    endcase
  endtask

  // Random slot that is (want = 1) or is not (want = 0) on the list; -1 if none.
  function automatic int pick_slot(input bit want);
    int s;
    s = $urandom_range(NODES - 1);
    for (int i = 0; i < NODES; i++) begin
      if (in_list[(s + i) % NODES] == want) return (s + i) % NODES;
    end
    return -1;
  endfunction

  function automatic logic signed [31:0] pick_key();
    int s;
    case ($urandom_range(9))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      2, 3: begin
        s = pick_slot(1);
        return (s >= 0) ? slot_key[s] : $urandom;
      end
      4, 5:    return $signed($urandom_range(40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Build one random beat: mostly well-formed traffic, some noise.
  function automatic stim_row_t random_row();
    stim_row_t r;
    int s;
    int pick;
    r = '{default: '0};
    r.key = pick_key();
    pick = $urandom_range(99);
    if (pick < 8) begin
      r.cmd  = CMD_W'($urandom_range(7));
      r.node = NODE_W'($urandom);
      r.key  = $urandom;
      return r;
    end
    // Bias toward removal once the list grows long.
    if (list_len > 40 && pick < 50) pick = pick + 50;
    if (pick < 40) begin
      r.cmd = (pick < 24) ? CMD_INSERT : (pick < 32) ? CMD_PUSH : CMD_UNSHIFT;
      s = pick_slot(0);
      r.node = (s >= 0 && $urandom_range(9) != 0) ? s[NODE_W-1:0] : NODE_W'($urandom);
    end else if (pick < 60) begin
      r.cmd = CMD_SEARCH;
    end else if (pick < 80) begin
      r.cmd = CMD_DELETE;
      s = pick_slot(1);
      r.node = (s >= 0 && $urandom_range(7) != 0) ? s[NODE_W-1:0] : NODE_W'($urandom);
    end else begin
      r.cmd = (pick < 90) ? CMD_POP : CMD_SHIFT;
      r.node = NODE_W'($urandom);
    end
    return r;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] c, input int n, input logic signed [31:0] k,
                         input bit typed = 0, input logic [STATUS_W-1:0] st = ST_DONE,
                         input int no = 0, input logic nv = 1'b0);
    directed.push_back('{c, n[NODE_W-1:0], k, typed, st, no[NODE_W-1:0], nv});
  endtask

  // Present one beat and hold it until the core takes it.
  task automatic send_beat(input stim_row_t r);
    answer_t a;
    start_i   <= 1'b1;
    command_i <= r.cmd;
    node_i    <= r.node;
    key_i     <= r.key;
    do @(posedge clk_i); while (busy_o);
    apply_list_cmd(r.cmd, r.node, r.key, a);
    if (r.typed) a = '{r.status, r.node_out, r.node_valid};
    pending_answers.push_back(a);
  endtask

  task automatic hold_gap(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Check each result beat against the oldest pending answer.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        answer_t w;
        w = pending_answers.pop_front();
        if (status_o !== w.status)         report_mismatch("status", status_o, w.status);
        if (node_out_o !== w.node_out)     report_mismatch("node_out", node_out_o, w.node_out);
        if (node_valid_o !== w.node_valid) report_mismatch("node_valid", node_valid_o,
                                                           w.node_valid);
      end
    end
  end

  // Watchdog: any beat in either direction counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("linked_list_deque_sorted_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int burst;
    int sent;
    int waited;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    command_i   = CMD_PUSH;
    node_i      = '0;
    key_i       = '0;
    list_head   = NIL;
    list_tail   = NIL;
    list_len    = 0;
    for (int i = 0; i < NODES; i++) begin
      link_next[i] = NIL;
      link_prev[i] = NIL;
      slot_key[i]  = '0;
      in_list[i]   = 0;
    end

    // Directed rows: empty list, extremes, each reject path.
    add_row(CMD_POP,     0,   0,       1, ST_EMPTY,  0,   1'b0);
    add_row(CMD_SHIFT,   0,   0,       1, ST_EMPTY,  0,   1'b0);
    add_row(CMD_SEARCH,  0,   0,       1, ST_EMPTY,  0,   1'b0);
    add_row(CMD_DELETE,  3,   0,       1, ST_REJECT, 3,   1'b1);
    add_row(CMD_PUSH,    0,   KEY_MAX, 1, ST_DONE,   0,   1'b0);
    add_row(CMD_PUSH,    0,   5,       1, ST_REJECT, 0,   1'b1);
    add_row(CMD_UNSHIFT, 255, KEY_MIN, 1, ST_DONE,   0,   1'b0);
    add_row(CMD_UNSHIFT, 255, 1,       1, ST_REJECT, 255, 1'b1);
    add_row(CMD_INSERT,  7,   5,       1, ST_DONE,   0,   1'b0);
    add_row(CMD_INSERT,  8,   5,       1, ST_REJECT, 8,   1'b1);
    add_row(CMD_INSERT,  9,   KEY_MIN, 1, ST_REJECT, 9,   1'b1);
    add_row(CMD_INSERT,  7,   6,       1, ST_REJECT, 7,   1'b1);
    add_row(CMD_INSERT,  10,  -1);
    add_row(CMD_INSERT,  11,  KEY_MAX - 1);
    add_row(CMD_SEARCH,  0,   KEY_MIN, 1, ST_DONE,   255, 1'b1);
    add_row(CMD_SEARCH,  0,   KEY_MAX);
    add_row(CMD_SEARCH,  0,   12345,   1, ST_EMPTY,  0,   1'b0);
    add_row(CMD_UNUSED,  170, -1,      1, ST_REJECT, 0,   1'b0);
    add_row(CMD_DELETE,  7,   0,       1, ST_DONE,   7,   1'b1);
    add_row(CMD_DELETE,  7,   0,       1, ST_REJECT, 7,   1'b1);
    add_row(CMD_POP,     0,   0,       1, ST_DONE,   0,   1'b1);
    add_row(CMD_SHIFT,   0,   0,       1, ST_DONE,   255, 1'b1);
    add_row(CMD_POP,     0,   0);
    add_row(CMD_SHIFT,   0,   0);
    add_row(CMD_SHIFT,   0,   0,       1, ST_EMPTY,  0,   1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table back to back, no idling.
    foreach (directed[i]) send_beat(directed[i]);
    hold_gap(1);

    // Random traffic in bursts separated by random gaps.
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        send_beat(random_row());
        sent++;
        // Drain once mid-run so the core sees a start on an empty pipeline.
        if (sent == N_RANDOM / 2) begin
          start_i <= 1'b0;
          while (pending_answers.size() != 0) @(posedge clk_i);
        end
      end
      hold_gap(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30));
    end
    start_i <= 1'b0;

    waited = 0;
    while (pending_answers.size() != 0 && waited < 4 * LATENCY) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);

    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("linked_list_deque_sorted_core regression: pass");
    end else begin
      $display("linked_list_deque_sorted_core regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lld_pkg.sv
rtl/core/lld_cell.sv
rtl/core/linked_list_deque_sorted_core.sv
bench/tb_top.sv
